FILE: rtl/wbsp_pkg.sv
// Shared types and codes for the weighted bucket server picker.
`default_nettype none
package wbsp_pkg;
    // storage sizes
    localparam int MAX_SERVERS = 16;
    localparam int MAX_BUCKETS = 1024;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_REQ   = 2'd3;

    localparam logic [2:0] REG_BUCKET_COUNT = 3'd0;
    localparam logic [2:0] REG_SERVER_COUNT = 3'd1;
    localparam logic [2:0] REG_ERROR_LIMIT  = 3'd2;
    localparam logic [2:0] REG_BO_INTERVAL  = 3'd3;
    localparam logic [2:0] REG_BO_CAP       = 3'd4;
    localparam logic [2:0] REG_DEFAULT_BKT  = 3'd5;

    // per-server health record, held in one memory word
    typedef struct packed {
        logic        up;
        logic [15:0] err;
        logic [15:0] rem;
        logic [31:0] backoff;
        logic [31:0] removed_at;
    } t_srv_rec;

    localparam int SRV_REC_W = $bits(t_srv_rec);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_ERR_RD  = 9'b000000010,
        ST_ERR_WR  = 9'b000000100,
        ST_SW_RD   = 9'b000001000,
        ST_SW_MUL  = 9'b000010000,
        ST_SW_WR   = 9'b000100000,
        ST_WALK    = 9'b001000000,
        ST_DEF_RD  = 9'b010000000,
        ST_DEF_OUT = 9'b100000000
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/wbsp_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
`default_nettype none
module wbsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/weighted_bucket_server_picker_core.sv
// Top level: weighted round-robin server picker with a per-server circuit breaker.
//
//  channel | ports                                   | dir | handshake
//  item    | i_kind i_bucket_index i_server_id ...   | in  | i_start & !o_busy
//  result  | o_chosen_server o_all_down o_no_table   | out | o_valid, one cycle
//  config  | i_cfg_we i_cfg_index i_cfg_data         | in  | i_cfg_we
//
// Load and set items finish on acceptance; an error item passes through accept, read
// and write. A request sweeps the servers (read, multiply, write per server), checks
// the table, walks the buckets in turn, and reads the default bucket when all are
// down. The result strobe comes in the first idle cycle. A read-modify-write of one
// memory entry completes before the next is read, so no forwarding is needed.
// Synchronous active-low reset clears control state and the server up bits.
// The bucket table is undefined until loaded. Results cannot be stalled.
`default_nettype none
module weighted_bucket_server_picker_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [9:0]  i_bucket_index,
    input  wire logic [3:0]  i_server_id,
    input  wire logic        i_initial_up,
    input  wire logic [31:0] i_now_seconds,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    output logic [3:0]       o_chosen_server,
    output logic             o_all_down,
    output logic             o_no_table
);
    localparam int SW = (wbsp_pkg::MAX_SERVERS > 1) ? $clog2(wbsp_pkg::MAX_SERVERS) : 1;
    localparam int BW = (wbsp_pkg::MAX_BUCKETS > 1) ? $clog2(wbsp_pkg::MAX_BUCKETS) : 1;
    localparam int SRV_DEPTH = 1 << SW;
    localparam int BKT_DEPTH = 1 << BW;
    localparam int SCW = $clog2(wbsp_pkg::MAX_SERVERS + 1);
    localparam int BCW = $clog2(wbsp_pkg::MAX_BUCKETS + 1);

    // configuration registers
    logic [10:0] r_bucket_count;
    logic [4:0]  r_server_count;
    logic [15:0] r_error_limit;
    logic [31:0] r_bo_interval;
    logic [31:0] r_bo_cap;
    logic [9:0]  r_default_bkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= '0;
            r_server_count <= '0;
            r_error_limit  <= 16'd3;
            r_bo_interval  <= 32'd60;
            r_bo_cap       <= 32'd600;
            r_default_bkt  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wbsp_pkg::REG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[10:0];
                wbsp_pkg::REG_SERVER_COUNT: r_server_count <= i_cfg_data[4:0];
                wbsp_pkg::REG_ERROR_LIMIT:  r_error_limit  <= i_cfg_data[15:0];
                wbsp_pkg::REG_BO_INTERVAL:  r_bo_interval  <= i_cfg_data;
                wbsp_pkg::REG_BO_CAP:       r_bo_cap       <= i_cfg_data;
                wbsp_pkg::REG_DEFAULT_BKT:  r_default_bkt  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // effective counts, clamped to the storage
    logic [SCW-1:0] ns;
    logic [BCW-1:0] nb;
    always_comb begin
        if (32'(r_server_count) > 32'(wbsp_pkg::MAX_SERVERS)) ns = SCW'(wbsp_pkg::MAX_SERVERS);
        else ns = SCW'(r_server_count);
        if (32'(r_bucket_count) > 32'(wbsp_pkg::MAX_BUCKETS)) nb = BCW'(wbsp_pkg::MAX_BUCKETS);
        else nb = BCW'(r_bucket_count);
    end

    // server record memory; up bits live in flops so reset clears them
    logic                          srv_we;
    logic [SW-1:0]                 srv_waddr, srv_raddr;
    wbsp_pkg::t_srv_rec            srv_wrec, srv_rrec_raw, srv_rrec;
    logic [wbsp_pkg::SRV_REC_W-1:0] srv_rdata;
    logic [SRV_DEPTH-1:0]          r_up, r_rec_valid;

    wbsp_ram #(.WIDTH(wbsp_pkg::SRV_REC_W), .DEPTH(SRV_DEPTH)) u_srv_ram (
        .i_clk  (i_clk),
        .i_we   (srv_we),
        .i_waddr(srv_waddr),
        .i_wdata(srv_wrec),
        .i_raddr(srv_raddr),
        .o_rdata(srv_rdata)
    );

    // bucket table memory
    logic          bkt_we;
    logic [BW-1:0] bkt_waddr, bkt_raddr;
    logic [3:0]    bkt_rdata;

    wbsp_ram #(.WIDTH(4), .DEPTH(BKT_DEPTH)) u_bkt_ram (
        .i_clk  (i_clk),
        .i_we   (bkt_we),
        .i_waddr(bkt_waddr),
        .i_wdata(i_server_id),
        .i_raddr(bkt_raddr),
        .o_rdata(bkt_rdata)
    );

    // control
    wbsp_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_sid, n_sid;
    logic [SCW-1:0]   r_sidx, n_sidx;
    logic [BCW-1:0]   r_pos, n_pos;
    logic [BCW-1:0]   r_steps, n_steps;
    logic [31:0]      r_now;
    logic             r_valid, n_valid;
    logic [3:0]       r_chosen, n_chosen;
    logic             r_alldn, n_alldn, r_notbl, n_notbl;
    wbsp_pkg::t_srv_rec r_rec, n_rec;
    logic [47:0]      r_prod;
    logic             r_remove, n_remove;

    logic             accept;
    logic [BCW-1:0]   pos_next;
    logic [31:0]      elapsed;

    assign accept = i_start && (r_state == wbsp_pkg::ST_IDLE);
    assign o_busy = (r_state != wbsp_pkg::ST_IDLE);

    // record as seen: never-written entries read as all zero
    always_comb begin
        srv_rrec_raw = wbsp_pkg::t_srv_rec'(srv_rdata);
        srv_rrec = srv_rrec_raw;
        if (!r_rec_valid[r_sid]) srv_rrec = '0;
        srv_rrec.up = r_up[r_sid];
    end

    assign elapsed  = r_now - srv_rrec.removed_at;
    assign pos_next = (r_pos + BCW'(1) >= nb) ? '0 : r_pos + BCW'(1);

    always_comb begin
        n_state  = r_state;
        n_sid    = r_sid;
        n_sidx   = r_sidx;
        n_pos    = r_pos;
        n_steps  = r_steps;
        n_valid  = 1'b0;
        n_chosen = r_chosen;
        n_alldn  = r_alldn;
        n_notbl  = r_notbl;
        n_rec    = r_rec;
        n_remove = r_remove;
        srv_we    = 1'b0;
        srv_waddr = r_sid;
        srv_wrec  = r_rec;
        srv_raddr = r_sid;
        bkt_we    = 1'b0;
        bkt_waddr = i_bucket_index[BW-1:0];
        bkt_raddr = pos_next[BW-1:0];
        case (r_state)
            wbsp_pkg::ST_IDLE: begin
                if (accept) begin
                    n_sid = i_server_id[SW-1:0];
                    case (i_kind)
                        wbsp_pkg::KIND_LOAD: begin
                            bkt_we = 1'b1;
                            if (i_bucket_index[BW-1:0] == '0) n_pos = '0;
                        end
                        wbsp_pkg::KIND_SET: begin
                            srv_we    = 1'b1;
                            srv_waddr = i_server_id[SW-1:0];
                            srv_wrec  = '0;
                        end
                        wbsp_pkg::KIND_ERROR: begin
                            srv_raddr = i_server_id[SW-1:0];
                            n_state   = wbsp_pkg::ST_ERR_RD;
                        end
                        default: begin
                            n_sid  = '0;
                            n_sidx = '0;
                            srv_raddr = '0;
                            n_state = wbsp_pkg::ST_SW_RD;
                        end
                    endcase
                end
            end
            wbsp_pkg::ST_ERR_RD: begin
                n_rec = srv_rrec;
                if (srv_rrec.err != 16'hFFFF) n_rec.err = srv_rrec.err + 16'd1;
                n_state = wbsp_pkg::ST_ERR_WR;
            end
            wbsp_pkg::ST_ERR_WR: begin
                srv_we  = 1'b1;
                n_state = wbsp_pkg::ST_IDLE;
            end
            wbsp_pkg::ST_SW_RD: begin
                if (r_sidx >= ns) begin
                    // sweep done: start walking, or report an empty table
                    n_steps = '0;
                    if (nb == '0) begin
                        n_valid  = 1'b1;
                        n_chosen = '0;
                        n_alldn  = 1'b0;
                        n_notbl  = 1'b1;
                        n_state  = wbsp_pkg::ST_IDLE;
                    end else begin
                        n_pos   = pos_next;
                        n_state = wbsp_pkg::ST_WALK;
                    end
                end else begin
                    n_rec    = srv_rrec;
                    n_remove = 1'b0;
                    // reinstate a down server whose back-off ran out or whose removal time lies ahead
                    if (!srv_rrec.up && srv_rrec.removed_at != '0 &&
                        (r_now < srv_rrec.removed_at || elapsed > srv_rrec.backoff)) begin
                        n_rec.up = 1'b1;
                        n_rec.backoff = '0;
                        n_rec.removed_at = '0;
                        n_rec.err = '0;
                    end
                    if (n_rec.up && n_rec.err >= r_error_limit) begin
                        n_remove = 1'b1;
                        if (n_rec.rem != 16'hFFFF) n_rec.rem = n_rec.rem + 16'd1;
                    end
                    n_state = wbsp_pkg::ST_SW_MUL;
                end
            end
            wbsp_pkg::ST_SW_MUL: begin
                if (r_remove) begin
                    n_rec.up = 1'b0;
                    n_rec.removed_at = r_now;
                    if (r_prod >= 48'(r_bo_cap)) n_rec.backoff = r_bo_cap;
                    else n_rec.backoff = r_prod[31:0];
                end
                n_state = wbsp_pkg::ST_SW_WR;
            end
            wbsp_pkg::ST_SW_WR: begin
                srv_we    = 1'b1;
                n_sidx    = r_sidx + SCW'(1);
                n_sid     = r_sid + SW'(1);
                srv_raddr = r_sid + SW'(1);
                n_state   = wbsp_pkg::ST_SW_RD;
            end
            wbsp_pkg::ST_WALK: begin
                // bkt_rdata holds table[r_pos]
                n_steps = r_steps + BCW'(1);
                if (r_up[bkt_rdata[SW-1:0]]) begin
                    n_valid  = 1'b1;
                    n_chosen = bkt_rdata;
                    n_alldn  = 1'b0;
                    n_notbl  = 1'b0;
                    n_state  = wbsp_pkg::ST_IDLE;
                end else if (r_steps + BCW'(1) >= nb) begin
                    bkt_raddr = r_default_bkt[BW-1:0];
                    n_state   = wbsp_pkg::ST_DEF_RD;
                end else begin
                    n_pos = pos_next;
                end
            end
            wbsp_pkg::ST_DEF_RD: begin
                // keep the default bucket on the read port
                bkt_raddr = r_default_bkt[BW-1:0];
                n_state   = wbsp_pkg::ST_DEF_OUT;
            end
            wbsp_pkg::ST_DEF_OUT: begin
                n_valid  = 1'b1;
                n_chosen = bkt_rdata;
                n_alldn  = 1'b1;
                n_notbl  = 1'b0;
                n_state  = wbsp_pkg::ST_IDLE;
            end
            default: n_state = wbsp_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wbsp_pkg::ST_IDLE;
            r_pos       <= '0;
            r_valid     <= 1'b0;
            r_up        <= '0;
            r_rec_valid <= '0;
            r_sidx      <= '0;
            r_steps     <= '0;
            r_remove    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_valid  <= n_valid;
            r_sidx   <= n_sidx;
            r_steps  <= n_steps;
            r_remove <= n_remove;
            if (srv_we) begin
                r_up[srv_waddr]        <= (r_state == wbsp_pkg::ST_IDLE) ? i_initial_up
                                                                        : srv_wrec.up;
                r_rec_valid[srv_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sid    <= n_sid;
        r_rec    <= n_rec;
        r_chosen <= n_chosen;
        r_alldn  <= n_alldn;
        r_notbl  <= n_notbl;
        r_prod   <= n_rec.rem * r_bo_interval;
        if (accept) r_now <= i_now_seconds;
    end

    assign o_valid         = r_valid;
    assign o_chosen_server = r_chosen;
    assign o_all_down      = r_alldn;
    assign o_no_table      = r_notbl;

`ifndef NO_ASSERTIONS
    // a result only follows request work
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == wbsp_pkg::ST_WALK ||
                     $past(r_state) == wbsp_pkg::ST_DEF_OUT ||
                     $past(r_state) == wbsp_pkg::ST_SW_RD))
        else $error("result without request");
    // a result comes out with the return to idle
    a_idle_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == wbsp_pkg::ST_IDLE)
        else $error("result while still busy");
    // flags are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_all_down && o_no_table))
        else $error("both all_down and no_table");
`endif
endmodule
`default_nettype wire

FILE: bench/tb_weighted_bucket_server_picker_core.sv
// Testbench for the weighted bucket server picker: directed and random item traffic checked against a predictor.
`default_nettype none
module tb_weighted_bucket_server_picker_core;
    localparam int N_SRV     = 16;
    localparam int N_BKT     = 1024;
    localparam int N_LOADED  = 64;
    localparam int CYC_LIMIT = 3000000;

    typedef struct packed {
        logic [3:0] server;
        logic       all_down;
        logic       no_table;
    } t_pick;

    // Health and bucket state mirror plus the queue of predicted picks
    class pick_scoreboard;
        logic [10:0] bkt_count;
        logic [4:0]  srv_count;
        logic [15:0] err_limit;
        logic [31:0] bo_interval;
        logic [31:0] bo_cap;
        logic [9:0]  dflt_bucket;
        logic        up_flag[N_SRV];
        logic [15:0] err_cnt[N_SRV];
        logic [15:0] rem_cnt[N_SRV];
        logic [31:0] bo_time[N_SRV];
        logic [31:0] rem_at[N_SRV];
        logic [3:0]  bkt_srv[N_BKT];
        logic [9:0]  position;
        t_pick       pending[$];
        int          fails;
        int          n_picks;
        int          n_all_down;
        int          n_no_table;
        int          n_removed;
        int          n_reinstated;

        function new();
            bkt_count   = 11'd0;
            srv_count   = 5'd0;
            err_limit   = 16'd3;
            bo_interval = 32'd60;
            bo_cap      = 32'd600;
            dflt_bucket = 10'd0;
            position    = 10'd0;
            for (int i = 0; i < N_SRV; i++) begin
                up_flag[i] = 1'b0;
                err_cnt[i] = '0;
                rem_cnt[i] = '0;
                bo_time[i] = '0;
                rem_at[i]  = '0;
            end
            for (int i = 0; i < N_BKT; i++) bkt_srv[i] = '0;
            fails = 0;
            n_picks = 0;
            n_all_down = 0;
            n_no_table = 0;
            n_removed = 0;
            n_reinstated = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                wbsp_pkg::REG_BUCKET_COUNT: bkt_count   = data[10:0];
                wbsp_pkg::REG_SERVER_COUNT: srv_count   = data[4:0];
                wbsp_pkg::REG_ERROR_LIMIT:  err_limit   = data[15:0];
                wbsp_pkg::REG_BO_INTERVAL:  bo_interval = data;
                wbsp_pkg::REG_BO_CAP:       bo_cap      = data;
                wbsp_pkg::REG_DEFAULT_BKT:  dflt_bucket = data[9:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted item; requests queue their predicted pick
        function void note_item(logic [1:0] kind, logic [9:0] bidx, logic [3:0] sid,
                                logic up, logic [31:0] now_s);
            int ns;
            int nb;
            int pos;
            longint unsigned prod;
            t_pick want;
            case (kind)
                wbsp_pkg::KIND_LOAD: begin
                    bkt_srv[bidx] = sid;
                    if (bidx == 10'd0) position = 10'd0;
                end
                wbsp_pkg::KIND_SET: begin
                    up_flag[sid] = up;
                    err_cnt[sid] = '0;
                    rem_cnt[sid] = '0;
                    bo_time[sid] = '0;
                    rem_at[sid]  = '0;
                end
                wbsp_pkg::KIND_ERROR: begin
                    if (err_cnt[sid] != 16'hFFFF) err_cnt[sid]++;
                end
                default: begin
                    ns = (srv_count > N_SRV) ? N_SRV : srv_count;
                    nb = (bkt_count > N_BKT) ? N_BKT : bkt_count;
                    // reinstate servers whose back-off ran out (or time went backwards)
                    for (int i = 0; i < ns; i++) begin
                        if (!up_flag[i] && rem_at[i] != 0 &&
                            (now_s < rem_at[i] || (now_s - rem_at[i]) > bo_time[i])) begin
                            up_flag[i] = 1'b1;
                            bo_time[i] = '0;
                            rem_at[i]  = '0;
                            err_cnt[i] = '0;
                            n_reinstated++;
                        end
                    end
                    // trip the breaker on failing servers
                    for (int i = 0; i < ns; i++) begin
                        if (up_flag[i] && err_cnt[i] >= err_limit) begin
                            if (rem_cnt[i] != 16'hFFFF) rem_cnt[i]++;
                            prod = longint'(rem_cnt[i]) * longint'(bo_interval);
                            if (prod >= longint'(bo_cap)) prod = bo_cap;
                            bo_time[i] = prod[31:0];
                            rem_at[i]  = now_s;
                            up_flag[i] = 1'b0;
                            n_removed++;
                        end
                    end
                    want = '0;
                    if (nb == 0) begin
                        want.no_table = 1'b1;
                    end else begin
                        pos = position;
                        want.all_down = 1'b1;
                        for (int k = 0; k < nb; k++) begin
                            pos++;
                            if (pos >= nb) pos = 0;
                            if (up_flag[bkt_srv[pos]]) begin
                                want.all_down = 1'b0;
                                want.server = bkt_srv[pos];
                                break;
                            end
                        end
                        position = pos[9:0];
                        if (want.all_down) want.server = bkt_srv[dflt_bucket];
                    end
                    pending = {pending, want};
                end
            endcase
        endfunction

        function void check_result(logic [3:0] server, logic all_down, logic no_table);
            t_pick want;
            if (pending.size() == 0) begin
                $error("unexpected result: server %0d all_down %0b no_table %0b",
                       server, all_down, no_table);
                fails++;
                return;
            end
            want = pending.pop_front();
            n_picks++;
            if (want.all_down) n_all_down++;
            if (want.no_table) n_no_table++;
            if (server !== want.server) begin
                $error("chosen_server: expected %0d, got %0d", want.server, server);
                fails++;
            end
            if (all_down !== want.all_down) begin
                $error("all_down: expected %0b, got %0b", want.all_down, all_down);
                fails++;
            end
            if (no_table !== want.no_table) begin
                $error("no_table: expected %0b, got %0b", want.no_table, no_table);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_kind;
    logic [9:0]  i_bucket_index;
    logic [3:0]  i_server_id;
    logic        i_initial_up;
    logic [31:0] i_now_seconds;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [3:0]  o_chosen_server;
    logic        o_all_down;
    logic        o_no_table;

    weighted_bucket_server_picker_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_bucket_index (i_bucket_index),
        .i_server_id    (i_server_id),
        .i_initial_up   (i_initial_up),
        .i_now_seconds  (i_now_seconds),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_chosen_server(o_chosen_server),
        .o_all_down     (o_all_down),
        .o_no_table     (o_no_table)
    );

    pick_scoreboard sb = new();
    int          cycles;
    bit          gaps_on;
    logic [31:0] clock_s;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_chosen_server, o_all_down, o_no_table);
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_weighted_bucket_server_picker_core: errors");
            $finish;
        end
    end

    // One item transfer; called and returns at a falling edge
    task automatic send_item(logic [1:0] kind, logic [9:0] bidx, logic [3:0] sid,
                             logic up, logic [31:0] now_s);
        bit done;
        done = 1'b0;
        i_start        = 1'b1;
        i_kind         = kind;
        i_bucket_index = bidx;
        i_server_id    = sid;
        i_initial_up   = up;
        i_now_seconds  = now_s;
        while (!done) begin
            @(posedge i_clk);
            if (!o_busy) begin
                done = 1'b1;
                sb.note_item(kind, bidx, sid, up, now_s);
            end
            @(negedge i_clk);
        end
    endtask

    // Random idle gap on the sender side, mostly short
    task automatic sender_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) n = 0;
        else if (r < 93) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n > 0) begin
            i_start = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Drain all results and let the block go idle; ends at a falling edge
    task automatic drain_idle();
        int quiet;
        i_start = 1'b0;
        @(negedge i_clk);
        while (sb.pending.size() != 0) @(negedge i_clk);
        quiet = 0;
        while (quiet < 3) begin
            @(posedge i_clk);
            quiet = o_busy ? 0 : quiet + 1;
        end
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [10:0] bc, logic [4:0] sc, logic [15:0] el,
                              logic [31:0] bi, logic [31:0] cap, logic [9:0] db);
        drain_idle();
        write_cfg(wbsp_pkg::REG_BUCKET_COUNT, {21'd0, bc});
        write_cfg(wbsp_pkg::REG_SERVER_COUNT, {27'd0, sc});
        write_cfg(wbsp_pkg::REG_ERROR_LIMIT, {16'd0, el});
        write_cfg(wbsp_pkg::REG_BO_INTERVAL, bi);
        write_cfg(wbsp_pkg::REG_BO_CAP, cap);
        write_cfg(wbsp_pkg::REG_DEFAULT_BKT, {22'd0, db});
    endtask

    // Time mostly creeps forward, sometimes jumps, goes back or reads zero
    task automatic next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) clock_s = clock_s + $urandom_range(0, 3);
        else if (r < 92) clock_s = $urandom();
        else if (r < 97) clock_s = clock_s - $urandom_range(1, 20);
        else clock_s = 32'd0;
    endtask

    task automatic random_items(int count, int bkt_span);
        int r;
        logic [9:0] bidx;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            sender_gap();
            if (r < 40) begin
                next_time();
                send_item(wbsp_pkg::KIND_REQ, 10'($urandom()), 4'($urandom()),
                          1'($urandom()), clock_s);
            end else if (r < 72) begin
                send_item(wbsp_pkg::KIND_ERROR, 10'($urandom()), 4'($urandom_range(0, 15)),
                          1'($urandom()), $urandom());
            end else if (r < 82) begin
                send_item(wbsp_pkg::KIND_SET, 10'($urandom()), 4'($urandom_range(0, 15)),
                          ($urandom_range(0, 9) < 7), $urandom());
            end else begin
                bidx = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, bkt_span - 1))
                                                 : 10'($urandom());
                send_item(wbsp_pkg::KIND_LOAD, bidx, 4'($urandom()), 1'($urandom()),
                          $urandom());
            end
        end
    endtask

    initial begin
        cycles         = 0;
        gaps_on        = 1'b1;
        clock_s        = 32'd100;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_kind         = wbsp_pkg::KIND_LOAD;
        i_bucket_index = '0;
        i_server_id    = '0;
        i_initial_up   = 1'b0;
        i_now_seconds  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = wbsp_pkg::REG_BUCKET_COUNT;
        i_cfg_data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty table under reset settings
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'd5);

        // define every server record and the buckets in use before any walk
        gaps_on = 1'b0;
        for (int i = 0; i < N_SRV; i++) send_item(wbsp_pkg::KIND_SET, '0, 4'(i), 1'b1, '0);
        for (int i = 0; i < N_LOADED; i++)
            send_item(wbsp_pkg::KIND_LOAD, 10'(i), 4'(i % N_SRV), 1'b0, '0);
        gaps_on = 1'b1;

        // directed: small table, fast breaker
        set_config(11'd8, 5'd16, 16'd1, 32'd1, 32'd3, 10'd5);
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'hFFFF_FFFF);
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'd0);
        send_item(wbsp_pkg::KIND_ERROR, '0, 4'd1, 1'b0, '0);
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'd0);      // removal at time zero
        send_item(wbsp_pkg::KIND_ERROR, '0, 4'd2, 1'b0, '0);
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'd50);
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'd20);     // time going backwards
        send_item(wbsp_pkg::KIND_SET, '0, 4'd15, 1'b0, '0);
        send_item(wbsp_pkg::KIND_LOAD, 10'd3, 4'd15, 1'b0, '0);
        send_item(wbsp_pkg::KIND_LOAD, 10'd0, 4'd4, 1'b0, '0);   // position restarts
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'd60);
        for (int i = 0; i < N_SRV; i++) send_item(wbsp_pkg::KIND_SET, '0, 4'(i), 1'b0, '0);
        send_item(wbsp_pkg::KIND_REQ, '0, '0, 1'b0, 32'd61);     // all down, default bucket
        // hold off until everything has come back
        drain_idle();
        for (int i = 0; i < N_SRV; i++) send_item(wbsp_pkg::KIND_SET, '0, 4'(i), 1'b1, '0);

        // extremes: oversized server count, maximal timing registers
        set_config(11'(N_LOADED), 5'd31, 16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   10'(N_LOADED - 1));
        random_items(40, N_LOADED);
        // zero error limit trips every up server on each request
        set_config(11'd1, 5'd4, 16'd0, 32'd2, 32'd10, 10'd0);
        random_items(40, 2);
        set_config(11'd16, 5'd8, 16'd2, 32'd3, 32'd0, 10'd7);
        random_items(80, 16);
        set_config(11'(N_LOADED), 5'd16, 16'd3, 32'd60, 32'd600, 10'd40);
        random_items(40, N_LOADED);
        set_config(11'd0, 5'd16, 16'd1, 32'd1, 32'd1, 10'd0);
        random_items(15, 8);

        for (int p = 0; p < 10; p++) begin
            set_config(11'($urandom_range(1, 32)), 5'($urandom_range(0, 31)),
                       16'($urandom_range(0, 5)), 32'($urandom_range(0, 7)),
                       32'($urandom_range(0, 40)), 10'($urandom_range(0, N_LOADED - 1)));
            gaps_on = (p % 3 != 2);
            random_items(56, 32);
        end
        gaps_on = 1'b1;

        drain_idle();
        repeat (40) @(negedge i_clk);
        $display("checked %0d picks (%0d all down, %0d empty table)",
                 sb.n_picks, sb.n_all_down, sb.n_no_table);
        $display("breaker trips %0d, reinstatements %0d", sb.n_removed, sb.n_reinstated);
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("tb_weighted_bucket_server_picker_core: clean");
        end else begin
            $display("tb_weighted_bucket_server_picker_core: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/wbsp_pkg.sv
rtl/wbsp_ram.sv
rtl/weighted_bucket_server_picker_core.sv
bench/tb_weighted_bucket_server_picker_core.sv
